// ----- src/sha1_message_digest_top_assert.svh -----
// assertion macros shared by the sha1 digest checker
// no dependencies; included by files that assert
`ifndef SHA1_MESSAGE_DIGEST_TOP_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_TOP_ASSERT_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define SHA1MD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("sha1 digest check failed");

// next-cycle implication
`define SHA1MD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("sha1 digest check failed");

`endif

// ----- src/sha1md_pkg.sv -----
// types, constants and round functions of the sha1 digest block
// no dependencies
package sha1md_pkg;

    typedef enum logic [1:0] {
        OP_ABSORB     = 2'd0,
        OP_ABSORB_FIN = 2'd1,
        OP_FIN        = 2'd2,
        OP_NONE       = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAD80,
        ST_PADZ,
        ST_PLEN,
        ST_CLOAD,
        ST_CROUND,
        ST_CWB,
        ST_OREAD,
        ST_OWAIT
    } t_state;

    // where to go once a compression is done
    typedef enum logic [1:0] {
        CONT_IDLE,
        CONT_PAD80,
        CONT_PADZ,
        CONT_OUT
    } t_cont;

    typedef enum logic [1:0] {
        RND_HOLD,
        RND_LOAD,
        RND_STEP
    } t_rnd_op;

    typedef struct packed {
        t_rnd_op    op;
        logic [6:0] idx;
    } t_rnd_ctl;

    typedef struct packed {
        logic        wr_en;
        logic [3:0]  wr_word;
        logic [1:0]  wr_lane;
        logic [7:0]  wr_byte;
        logic        rd_en;
        logic [3:0]  rd_word;
    } t_buf_req;

    typedef struct packed {
        logic        rd_en;
        logic [2:0]  rd_addr;
        logic        wr_en;
        logic [2:0]  wr_addr;
        logic [31:0] wr_data;
        logic        clear;
    } t_chain_req;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam logic [5:0] BLOCK_LAST   = 6'd63;
    localparam logic [5:0] LEN_POS      = 6'd56;
    localparam logic [6:0] ROUND_LAST   = 7'd79;
    localparam logic [6:0] SCHED_LOAD   = 7'd15;
    localparam logic [6:0] SCHED_WORDS  = 7'd16;
    localparam logic [6:0] MEM_SWEEP    = 7'd5;
    localparam logic [2:0] DIGEST_LAST  = 3'd4;

    function automatic logic [31:0] sha1md_init_word(input logic [2:0] idx);
        logic [31:0] w;
        unique case (idx)
            3'd0:    w = H0;
            3'd1:    w = H1;
            3'd2:    w = H2;
            3'd3:    w = H3;
            3'd4:    w = H4;
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] sha1md_k(input logic [6:0] idx);
        logic [31:0] k;
        priority if (idx < 7'd20) k = K0;
        else if (idx < 7'd40)     k = K1;
        else if (idx < 7'd60)     k = K2;
        else                      k = K3;
        return k;
    endfunction

    function automatic logic [31:0] sha1md_f(input logic [6:0] idx,
                                             input logic [31:0] b,
                                             input logic [31:0] c,
                                             input logic [31:0] d);
        logic [31:0] f;
        priority if (idx < 7'd20)                f = (b & c) | (~b & d);
        else if (idx < 7'd40 || idx >= 7'd60)    f = b ^ c ^ d;
        else                                     f = (b & c) | (b & d) | (c & d);
        return f;
    endfunction

endpackage

// ----- src/sha1md_if.sv -----
// valid/ready channel interfaces of the sha1 digest block
// no dependencies
interface sha1md_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] data_byte;

    modport source(output valid, output op, output data_byte, input ready);
    modport sink(input valid, input op, input data_byte, output ready);
endinterface

interface sha1md_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source(output valid, output digest_word, output word_index,
                   output last_word, input ready);
    modport sink(input valid, input digest_word, input word_index,
                 input last_word, output ready);
endinterface

// ----- src/sha1md_buf_mem.sv -----
// 64-byte block buffer held as 16 words with byte-lane writes
// depends on sha1md_pkg
module sha1md_buf_mem (
    input  logic                 i_clk,
    input  sha1md_pkg::t_buf_req i_req,
    output logic [31:0]          o_rd_word
);
    import sha1md_pkg::*;

    logic [3:0][7:0] r_mem [16];
    logic [31:0]     r_rd_word;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_word][i_req.wr_lane] <= i_req.wr_byte;
        end
        if (i_req.rd_en) begin
            r_rd_word <= r_mem[i_req.rd_word];
        end
    end

    assign o_rd_word = r_rd_word;

endmodule

// ----- src/sha1md_chain_mem.sv -----
// five chaining words in a small memory; unwritten entries read as the initial hash
// depends on sha1md_pkg
module sha1md_chain_mem (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sha1md_pkg::t_chain_req i_req,
    output logic [31:0]            o_rd_data
);
    import sha1md_pkg::*;

    logic [31:0] r_mem [5];
    logic [4:0]  r_valid;
    logic [31:0] r_rd_data;
    logic        r_rd_valid;
    logic [2:0]  r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
            r_rd_addr <= i_req.rd_addr;
        end
    end

    // valid bits stand in for a clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.clear) begin
                r_valid <= '0;
            end else if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : sha1md_init_word(r_rd_addr);

endmodule

// ----- src/sha1md_round.sv -----
// sha1 round datapath: working words a..e and the 16-word schedule window
// depends on sha1md_pkg
module sha1md_round (
    input  logic                 i_clk,
    input  sha1md_pkg::t_rnd_ctl i_ctl,
    input  logic [31:0]          i_load_word,
    input  logic [31:0]          i_buf_word,
    output logic [31:0]          o_a
);
    import sha1md_pkg::*;

    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_w [16];
    logic [31:0] w_mix;
    logic [31:0] w_cur;
    logic [31:0] n_t;

    // r_w[0] is the newest schedule word
    always_comb begin
        w_mix = r_w[2] ^ r_w[7] ^ r_w[13] ^ r_w[15];
        w_cur = (i_ctl.idx < SCHED_WORDS) ? i_buf_word : {w_mix[30:0], w_mix[31]};
        n_t   = {r_a[26:0], r_a[31:27]} + sha1md_f(i_ctl.idx, r_b, r_c, r_d)
              + r_e + w_cur + sha1md_k(i_ctl.idx);
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            RND_LOAD: begin
                r_a <= r_b;
                r_b <= r_c;
                r_c <= r_d;
                r_d <= r_e;
                r_e <= i_load_word;
            end
            RND_STEP: begin
                r_a <= n_t;
                r_b <= r_a;
                r_c <= {r_b[1:0], r_b[31:2]};
                r_d <= r_c;
                r_e <= r_d;
                r_w[0] <= w_cur;
                for (int i = 1; i < 16; i++) begin
                    r_w[i] <= r_w[i-1];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_a = r_a;

endmodule

// ----- src/sha1_message_digest_top.sv -----
// sha1 digest of a byte stream, top level: sequencer over buffer and chain memories
// depends on sha1md_pkg, sha1md_if, sha1md_buf_mem, sha1md_chain_mem, sha1md_round
//
//  channel | dir | payload                              | request means
//  i_in    | in  | op, data_byte                        | one byte and/or finish
//  o_out   | out | digest_word, word_index, last_word   | one digest word
//
// an absorbed byte is written straight into the block buffer; filling the 64th byte adds a
// compression (chain loads, rounds on one shared round unit, write-backs)
// finish pads one byte per cycle while no compression runs, idles before the length, then
// 1 or 2 compressions; each digest word is read (ST_OREAD), then offered (ST_OWAIT) until taken
// no item is taken from the end of a finish request until the fifth word is taken
// reset is synchronous; the chain memory uses valid bits, so there is no clearing pass
module sha1_message_digest_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sha1md_in_if.sink           i_in,
    sha1md_out_if.source        o_out
);
    import sha1md_pkg::*;

    t_state      r_state, n_state;
    t_cont       r_cont, n_cont;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bitcnt, n_bitcnt;
    logic [6:0]  r_cnt, n_cnt;

    t_buf_req    buf_req;
    t_chain_req  chain_req;
    t_rnd_ctl    rnd_ctl;
    logic [31:0] buf_word;
    logic [31:0] chain_word;
    logic [31:0] rnd_a;
    logic        in_acc;
    logic        out_acc;
    t_op         op;
    logic        is_absorb;
    logic [2:0]  len_idx;

    assign op        = t_op'(i_in.op);
    assign is_absorb = (op == OP_ABSORB) || (op == OP_ABSORB_FIN);
    assign in_acc    = i_in.valid && i_in.ready;
    assign out_acc   = o_out.valid && o_out.ready;
    assign len_idx   = r_fill[2:0];

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = (r_state == ST_OWAIT);
    assign o_out.digest_word = chain_word;
    assign o_out.word_index  = r_cnt[2:0];
    assign o_out.last_word   = (r_cnt[2:0] == DIGEST_LAST);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (op)
                        OP_ABSORB:     n_state = (r_fill == BLOCK_LAST) ? ST_CLOAD : ST_IDLE;
                        OP_ABSORB_FIN: n_state = (r_fill == BLOCK_LAST) ? ST_CLOAD : ST_PAD80;
                        OP_FIN:        n_state = ST_PAD80;
                        OP_NONE:       n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PAD80: n_state = (r_fill == BLOCK_LAST) ? ST_CLOAD : ST_PADZ;
            ST_PADZ: begin
                priority if (r_fill == LEN_POS) n_state = ST_PLEN;
                else if (r_fill == BLOCK_LAST)  n_state = ST_CLOAD;
                else                            n_state = ST_PADZ;
            end
            ST_PLEN:   n_state = (r_fill == BLOCK_LAST) ? ST_CLOAD : ST_PLEN;
            ST_CLOAD:  n_state = (r_cnt == MEM_SWEEP) ? ST_CROUND : ST_CLOAD;
            ST_CROUND: n_state = (r_cnt == ROUND_LAST) ? ST_CWB : ST_CROUND;
            ST_CWB: begin
                if (r_cnt == MEM_SWEEP) begin
                    unique case (r_cont)
                        CONT_IDLE:  n_state = ST_IDLE;
                        CONT_PAD80: n_state = ST_PAD80;
                        CONT_PADZ:  n_state = ST_PADZ;
                        CONT_OUT:   n_state = ST_OREAD;
                    endcase
                end
            end
            ST_OREAD: n_state = ST_OWAIT;
            ST_OWAIT: begin
                if (out_acc) begin
                    n_state = (r_cnt[2:0] == DIGEST_LAST) ? ST_IDLE : ST_OREAD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // counters, fill index, bit count
    always_comb begin
        n_cont   = r_cont;
        n_fill   = r_fill;
        n_bitcnt = r_bitcnt;
        n_cnt    = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (in_acc && is_absorb) begin
                    n_fill   = r_fill + 6'd1;
                    n_bitcnt = r_bitcnt + 64'd8;
                    n_cont   = (op == OP_ABSORB) ? CONT_IDLE : CONT_PAD80;
                end
            end
            ST_PAD80: begin
                n_fill = r_fill + 6'd1;
                n_cont = CONT_PADZ;
                n_cnt  = '0;
            end
            ST_PADZ: begin
                if (r_fill != LEN_POS) begin
                    n_fill = r_fill + 6'd1;
                end
                n_cont = CONT_PADZ;
                n_cnt  = '0;
            end
            ST_PLEN: begin
                n_fill = r_fill + 6'd1;
                n_cont = CONT_OUT;
                n_cnt  = '0;
            end
            ST_CLOAD:  n_cnt = (r_cnt == MEM_SWEEP) ? '0 : r_cnt + 7'd1;
            ST_CROUND: n_cnt = (r_cnt == ROUND_LAST) ? '0 : r_cnt + 7'd1;
            ST_CWB:    n_cnt = (r_cnt == MEM_SWEEP) ? '0 : r_cnt + 7'd1;
            ST_OREAD: begin
            end
            ST_OWAIT: begin
                if (out_acc) begin
                    if (r_cnt[2:0] == DIGEST_LAST) begin
                        n_cnt    = '0;
                        n_fill   = '0;
                        n_bitcnt = '0;
                    end else begin
                        n_cnt = r_cnt + 7'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // memory and round unit controls
    always_comb begin
        buf_req   = '0;
        chain_req = '0;
        rnd_ctl   = '{op: RND_HOLD, idx: r_cnt};
        buf_req.wr_word = r_fill[5:2];
        buf_req.wr_lane = ~r_fill[1:0];
        chain_req.wr_data = chain_word + rnd_a;
        unique case (r_state)
            ST_IDLE: begin
                buf_req.wr_en   = in_acc && is_absorb;
                buf_req.wr_byte = i_in.data_byte;
            end
            ST_PAD80: begin
                buf_req.wr_en   = 1'b1;
                buf_req.wr_byte = PAD_MARK;
            end
            ST_PADZ: begin
                buf_req.wr_en   = (r_fill != LEN_POS);
                buf_req.wr_byte = '0;
            end
            ST_PLEN: begin
                // big-endian length, most significant byte first
                buf_req.wr_en   = 1'b1;
                buf_req.wr_byte = 8'(r_bitcnt >> {~len_idx, 3'b000});
            end
            ST_CLOAD: begin
                chain_req.rd_en   = (r_cnt < MEM_SWEEP);
                chain_req.rd_addr = r_cnt[2:0];
                // prefetch schedule word 0 for the first round
                buf_req.rd_en     = (r_cnt == MEM_SWEEP);
                buf_req.rd_word   = '0;
                if (r_cnt != '0) begin
                    rnd_ctl.op = RND_LOAD;
                end
            end
            ST_CROUND: begin
                rnd_ctl.op      = RND_STEP;
                buf_req.rd_en   = (r_cnt < SCHED_LOAD);
                buf_req.rd_word = r_cnt[3:0] + 4'd1;
            end
            ST_CWB: begin
                // read word k while word k-1 is written back, never the same entry
                chain_req.rd_en   = (r_cnt < MEM_SWEEP);
                chain_req.rd_addr = r_cnt[2:0];
                if (r_cnt != '0) begin
                    chain_req.wr_en   = 1'b1;
                    chain_req.wr_addr = r_cnt[2:0] - 3'd1;
                    rnd_ctl.op        = RND_LOAD;
                end
            end
            ST_OREAD: begin
                chain_req.rd_en   = 1'b1;
                chain_req.rd_addr = r_cnt[2:0];
            end
            ST_OWAIT: begin
                chain_req.clear = out_acc && (r_cnt[2:0] == DIGEST_LAST);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cont   <= CONT_IDLE;
            r_fill   <= '0;
            r_bitcnt <= '0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_cont   <= n_cont;
            r_fill   <= n_fill;
            r_bitcnt <= n_bitcnt;
            r_cnt    <= n_cnt;
        end
    end

    sha1md_buf_mem u_buf_mem (
        .i_clk     (i_clk),
        .i_req     (buf_req),
        .o_rd_word (buf_word)
    );

    sha1md_chain_mem u_chain_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (chain_req),
        .o_rd_data (chain_word)
    );

    sha1md_round u_round (
        .i_clk       (i_clk),
        .i_ctl       (rnd_ctl),
        .i_load_word (chain_word),
        .i_buf_word  (buf_word),
        .o_a         (rnd_a)
    );

endmodule

// ----- src/sha1md_checker.sv -----
// port-level checks of the sha1 digest top, attached by bind
// depends on sha1_message_digest_top_assert.svh and sha1_message_digest_top
`include "sha1_message_digest_top_assert.svh"

module sha1md_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_word,
    input logic [2:0]  i_out_index,
    input logic        i_out_last
);

    logic       out_stall;
    logic       out_step;
    logic       idx_top;
    logic [2:0] idx_succ;

    assign out_stall = i_out_valid && !i_out_ready;
    assign out_step  = i_out_valid && i_out_ready && !i_out_last;
    assign idx_top   = (i_out_index == 3'd4);
    assign idx_succ  = i_out_index + 3'd1;

    // a stalled digest word holds
    `SHA1MD_ASSERT_NEXT(a_out_hold, out_stall, i_out_valid && $stable(i_out_word) && $stable(i_out_index))

    // no new request is taken while a digest is being delivered
    `SHA1MD_ASSERT_NOW(a_busy_out, i_out_valid, !i_in_ready)

    // last flag marks exactly the fifth word
    `SHA1MD_ASSERT_NOW(a_last_idx, i_out_valid, (i_out_index <= 3'd4) && (i_out_last == idx_top))

    // after each accepted word but the last, the next word follows in index order
    `SHA1MD_ASSERT_NOW(a_next_word, out_step, ##2 (i_out_valid && (i_out_index == $past(idx_succ, 2))))

endmodule

bind sha1_message_digest_top sha1md_checker u_sha1md_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  (o_out.digest_word),
    .i_out_index (o_out.word_index),
    .i_out_last  (o_out.last_word)
);

// ----- dv/tb_top.sv -----
// self-checking testbench for the sha1 digest block: byte requests in, digest words out
// depends on sha1md_pkg, sha1md_if and sha1_message_digest_top
// a local sha1 predictor checks every word; a few known digests are typed in directly
module tb_top;
    import sha1md_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_beat;

    typedef struct packed {
        t_op          op;
        logic [7:0]   data;
        logic         known;
        logic [159:0] digest;
    } t_dir_row;

    localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
    localparam logic [159:0] ABC_DIGEST   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;
    localparam int DIR_ROWS     = 12;
    localparam int RAND_ITEMS   = 140;
    localparam int RAND_MSGS    = 6;
    localparam int DRAIN_CYCLES = 120;
    localparam int TIMEOUT      = 20_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sha1md_in_if  in_ch();
    sha1md_out_if out_ch();

    sha1_message_digest_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    logic [31:0]  hash_words [5];
    logic [63:0]  msg_bits;
    logic [7:0]   blk_bytes [64];
    logic [6:0]   blk_fill;
    t_digest_beat digest_q [$];
    int           mismatch_count = 0;
    bit           quiet = 1'b0;
    t_dir_row     dir_rows [DIR_ROWS];

    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void hash_reset();
        hash_words[0] = H0;
        hash_words[1] = H1;
        hash_words[2] = H2;
        hash_words[3] = H3;
        hash_words[4] = H4;
        msg_bits = '0;
        blk_fill = '0;
    endfunction

    function automatic void compress_blk();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) begin
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        end
        for (int i = 16; i < 80; i++) begin
            w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        end
        a = hash_words[0];
        b = hash_words[1];
        c = hash_words[2];
        d = hash_words[3];
        e = hash_words[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d);
                k = K0;
            end else if (i < 40) begin
                f = b ^ c ^ d;
                k = K1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end else begin
                f = b ^ c ^ d;
                k = K3;
            end
            t = rotl(a, 5) + f + e + w[i] + k;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        hash_words[0] += a;
        hash_words[1] += b;
        hash_words[2] += c;
        hash_words[3] += d;
        hash_words[4] += e;
        blk_fill = '0;
    endfunction

    function automatic void absorb(input logic [7:0] v);
        blk_bytes[blk_fill[5:0]] = v;
        blk_fill = {1'b0, blk_fill[5:0]} + 7'd1;
        msg_bits += 64'd8;
        if (blk_fill == 7'd64) compress_blk();
    endfunction

    function automatic void finish_msg();
        int           pos;
        t_digest_beat beat;
        pos = int'(blk_fill[5:0]);
        blk_bytes[pos] = PAD_MARK;
        pos++;
        // length no longer fits: pad out and compress an extra block
        if (pos > int'(LEN_POS)) begin
            while (pos < 64) begin
                blk_bytes[pos] = 8'h00;
                pos++;
            end
            compress_blk();
            pos = 0;
        end
        while (pos < int'(LEN_POS)) begin
            blk_bytes[pos] = 8'h00;
            pos++;
        end
        for (int i = 0; i < 8; i++) begin
            blk_bytes[int'(LEN_POS) + i] = msg_bits[63 - 8*i -: 8];
        end
        compress_blk();
        for (int n = 0; n < 5; n++) begin
            beat.word = hash_words[n];
            beat.idx  = 3'(n);
            beat.last = (n == 4);
            digest_q.push_back(beat);
        end
        hash_reset();
    endfunction

    function automatic void predict_req(input t_op op, input logic [7:0] v);
        case (op)
            OP_ABSORB:     absorb(v);
            OP_ABSORB_FIN: begin
                absorb(v);
                finish_msg();
            end
            OP_FIN:        finish_msg();
            default:       ;
        endcase
    endfunction

    task automatic send_req(input t_op op, input logic [7:0] v);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.op        <= op;
        in_ch.data_byte <= v;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predict_req(op, v);
    endtask

    // output stalls
    initial begin
        out_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_digest_beat want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (digest_q.size() == 0) begin
                $error("digest_word: expected none, got %h", out_ch.digest_word);
                mismatch_count++;
            end else begin
                want = digest_q.pop_front();
                if (out_ch.digest_word !== want.word) begin
                    $error("digest_word: expected %h, got %h", want.word, out_ch.digest_word);
                    mismatch_count++;
                end
                if (out_ch.word_index !== want.idx) begin
                    $error("word_index: expected %0d, got %0d", want.idx, out_ch.word_index);
                    mismatch_count++;
                end
                if (out_ch.last_word !== want.last) begin
                    $error("last_word: expected %b, got %b", want.last, out_ch.last_word);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #(TIMEOUT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int rand_items;
        int rand_msgs;
        int msg_len;
        bit fin_on_byte;
        rand_items = 0;
        rand_msgs  = 0;
        in_ch.valid     <= 1'b0;
        in_ch.op        <= OP_ABSORB;
        in_ch.data_byte <= 8'h00;
        i_rst_n         <= 1'b0;
        hash_reset();
        dir_rows = '{
            '{OP_FIN,        8'h00, 1'b1, EMPTY_DIGEST},  // empty message
            '{OP_NONE,       8'hFF, 1'b0, 160'h0},        // unused op, ignored
            '{OP_ABSORB,     8'h61, 1'b0, 160'h0},
            '{OP_NONE,       8'h00, 1'b0, 160'h0},        // unused op inside a message
            '{OP_ABSORB,     8'h62, 1'b0, 160'h0},
            '{OP_ABSORB_FIN, 8'h63, 1'b1, ABC_DIGEST},
            '{OP_ABSORB_FIN, 8'h00, 1'b0, 160'h0},
            '{OP_ABSORB_FIN, 8'hFF, 1'b0, 160'h0},
            '{OP_ABSORB,     8'h80, 1'b0, 160'h0},
            '{OP_ABSORB,     8'h7F, 1'b0, 160'h0},
            '{OP_FIN,        8'hFF, 1'b0, 160'h0},        // byte ignored on finish
            '{OP_FIN,        8'h55, 1'b1, EMPTY_DIGEST}   // back-to-back finish
        };
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_req(dir_rows[r].op, dir_rows[r].data);
            // known digests override the predicted words
            if (dir_rows[r].known) begin
                for (int n = 0; n < 5; n++) begin
                    digest_q[digest_q.size() - 5 + n].word = dir_rows[r].digest[159 - 32*n -: 32];
                end
            end
        end

        // random messages, mostly short, some around the one/two block padding edge
        while (rand_items < RAND_ITEMS || rand_msgs < RAND_MSGS) begin
            msg_len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 10)
                                                 : $urandom_range(52, 70);
            fin_on_byte = (msg_len != 0) && ($urandom_range(0, 1) == 1);
            for (int n = 0; n < msg_len; n++) begin
                if ($urandom_range(0, 9) == 0) send_req(OP_NONE, 8'($urandom));
                send_req((fin_on_byte && n == msg_len - 1) ? OP_ABSORB_FIN : OP_ABSORB,
                         8'($urandom));
                rand_items++;
                quiet = (rand_items >= RAND_ITEMS - 30) && (rand_msgs >= RAND_MSGS - 2);
            end
            if (!fin_on_byte) begin
                send_req(OP_FIN, 8'($urandom));
                rand_items++;
            end
            rand_msgs++;
            quiet = (rand_items >= RAND_ITEMS - 30) && (rand_msgs >= RAND_MSGS - 2);
        end
        in_ch.valid <= 1'b0;

        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- sha1_message_digest_top.f -----
+incdir+src
src/sha1md_pkg.sv
src/sha1md_if.sv
src/sha1md_buf_mem.sv
src/sha1md_chain_mem.sv
src/sha1md_round.sv
src/sha1_message_digest_top.sv
src/sha1md_checker.sv
dv/tb_top.sv
